/* sv/pixel_blend_fill_unit_macros.svh */
// Assertion macros shared by the pixel blend fill unit.
`ifndef PIXEL_BLEND_FILL_UNIT_MACROS_SVH
`define PIXEL_BLEND_FILL_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PBF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbf assertion failed");
`define PBF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbf assertion failed");
`else
`define PBF_ASSERT_IMP(lbl, ante, cons)
`define PBF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/pbf_pkg.sv */
// Types, register indexes and reset values of the pixel blend fill unit.
package pbf_pkg;

  localparam int unsigned PixelW  = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumBytes = PixelW / ByteW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned OpW     = 3;

  typedef enum logic [OpW-1:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpMin  = 3'd2,
    OpMax  = 3'd3,
    OpMult = 3'd4
  } blend_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFillColor     = 2'd0,
    RegBlendOp       = 2'd1,
    RegAlphaMask     = 2'd2,
    RegAlphaIncluded = 2'd3
  } cfg_reg_e;

  localparam logic [PixelW-1:0] FillColorRst = 32'h0000_0000;
  localparam logic [PixelW-1:0] AlphaMaskRst = 32'hFF00_0000;

  // Settings seen by the datapath: the colour already adjusted for alpha.
  typedef struct packed {
    logic [PixelW-1:0] color;
    blend_op_e         op;
  } blend_cfg_t;

endpackage

/* sv/pbf_ifs.sv */
// Channel interfaces of the pixel blend fill unit: pixel in, pixel out, configuration.
interface pbf_dst_if;
  logic                         valid;
  logic                         ready;
  logic [pbf_pkg::PixelW-1:0]   dst_pixel;
  modport source (output valid, output dst_pixel, input ready);
  modport sink   (input valid, input dst_pixel, output ready);
endinterface

interface pbf_res_if;
  logic                         valid;
  logic                         ready;
  logic [pbf_pkg::PixelW-1:0]   blended_pixel;
  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface

interface pbf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pbf_pkg::CfgIdxW-1:0]  index;
  logic [pbf_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/pbf_cfg_regs.sv */
// Configuration registers and the alpha adjustment of the fill colour.
module pbf_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  pbf_cfg_if.sink             cfg_i,
  output pbf_pkg::blend_cfg_t blend_cfg_o
);

  logic [pbf_pkg::PixelW-1:0] fill_color_q;
  logic [pbf_pkg::OpW-1:0]    blend_op_q;
  logic [pbf_pkg::PixelW-1:0] alpha_mask_q;
  logic                       alpha_incl_q;
  logic                       wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q <= pbf_pkg::FillColorRst;
      blend_op_q   <= pbf_pkg::OpAdd;
      alpha_mask_q <= pbf_pkg::AlphaMaskRst;
      alpha_incl_q <= 1'b0;
    end else if (wr_en) begin
      case (pbf_pkg::cfg_reg_e'(cfg_i.index))
        pbf_pkg::RegFillColor:     fill_color_q <= cfg_i.data;
        pbf_pkg::RegBlendOp:       blend_op_q   <= cfg_i.data[pbf_pkg::OpW-1:0];
        pbf_pkg::RegAlphaMask:     alpha_mask_q <= cfg_i.data;
        pbf_pkg::RegAlphaIncluded: alpha_incl_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Min and mult leave alpha intact with a saturated colour byte; the
  // other operations need a zero one.
  always_comb begin
    blend_cfg_o.op    = pbf_pkg::blend_op_e'(blend_op_q);
    blend_cfg_o.color = fill_color_q;
    if (!alpha_incl_q) begin
      if (blend_op_q inside {pbf_pkg::OpMin, pbf_pkg::OpMult}) begin
        blend_cfg_o.color = fill_color_q | alpha_mask_q;
      end else begin
        blend_cfg_o.color = fill_color_q & ~alpha_mask_q;
      end
    end
  end

endmodule

/* sv/pbf_byte_alu.sv */
// Blend of one pixel byte with one colour byte.
module pbf_byte_alu (
  input  pbf_pkg::blend_op_e         op_i,
  input  logic [pbf_pkg::ByteW-1:0]  dst_i,
  input  logic [pbf_pkg::ByteW-1:0]  col_i,
  output logic [pbf_pkg::ByteW-1:0]  res_o
);

  logic [pbf_pkg::ByteW:0]     sum;
  logic [2*pbf_pkg::ByteW-1:0] prod;
  logic [2*pbf_pkg::ByteW-1:0] prod_rnd;

  assign sum      = {1'b0, dst_i} + {1'b0, col_i};
  assign prod     = {{pbf_pkg::ByteW{1'b0}}, dst_i} * {{pbf_pkg::ByteW{1'b0}}, col_i};
  // The largest product plus 255 still fits in 16 bits.
  assign prod_rnd = prod + {{pbf_pkg::ByteW{1'b0}}, {pbf_pkg::ByteW{1'b1}}};

  always_comb begin
    case (op_i)
      pbf_pkg::OpAdd:  res_o = sum[pbf_pkg::ByteW] ? {pbf_pkg::ByteW{1'b1}}
                                                  : sum[pbf_pkg::ByteW-1:0];
      pbf_pkg::OpSub:  res_o = (dst_i > col_i) ? dst_i - col_i : '0;
      pbf_pkg::OpMin:  res_o = (dst_i < col_i) ? dst_i : col_i;
      pbf_pkg::OpMax:  res_o = (dst_i > col_i) ? dst_i : col_i;
      pbf_pkg::OpMult: res_o = prod_rnd[2*pbf_pkg::ByteW-1:pbf_pkg::ByteW];
      default:         res_o = dst_i;
    endcase
  end

endmodule

/* sv/pixel_blend_fill_unit.sv */
// Top level of the pixel blend fill unit.
// Blends each 32-bit destination pixel, byte by byte, with the fill colour.
// Channels: dst_i takes pixels, res_o returns blended pixels, one result
// per pixel in order; cfg_i writes the four registers (fill colour, operation,
// alpha mask, alpha included) by index and is always ready.
// The user must make cfg_i transactions only with no pixel in flight; not enforced.
// Path: one input register and one result register, with the byte blend between them;
// a pixel accepted on dst_i is offered on res_o once it reaches the result register.
// Throughput: one pixel per clock unless res_o stalls (two-stage register pipeline).
// When res_o stalls, the result register holds its pixel and the input
// register keeps accepting until both stages are full; dst_i.ready then
// drops and rises again in the cycle the stall is released.
// Reset clears both stages and loads the register reset values: colour zero,
// add, alpha mask 0xFF000000, alpha preserved.
`include "pixel_blend_fill_unit_macros.svh"
module pixel_blend_fill_unit (
  input  logic clk_i,
  input  logic rst_ni,
  pbf_dst_if.sink   dst_i,
  pbf_res_if.source res_o,
  pbf_cfg_if.sink   cfg_i
);

  pbf_pkg::blend_cfg_t         blend_cfg;
  logic                        in_valid_q;
  logic [pbf_pkg::PixelW-1:0]  in_pixel_q;
  logic                        out_valid_q;
  logic [pbf_pkg::PixelW-1:0]  out_pixel_q;
  logic [pbf_pkg::PixelW-1:0]  out_pixel_d;
  logic                        out_ready;
  logic                        in_ready;

  pbf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .blend_cfg_o (blend_cfg)
  );

  assign out_ready   = !out_valid_q || res_o.ready;
  assign in_ready    = !in_valid_q || out_ready;
  assign dst_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= dst_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && dst_i.valid) begin
      in_pixel_q <= dst_i.dst_pixel;
    end
  end

  for (genvar b = 0; b < pbf_pkg::NumBytes; b++) begin : g_byte
    pbf_byte_alu u_byte_alu (
      .op_i  (blend_cfg.op),
      .dst_i (in_pixel_q[b*pbf_pkg::ByteW +: pbf_pkg::ByteW]),
      .col_i (blend_cfg.color[b*pbf_pkg::ByteW +: pbf_pkg::ByteW]),
      .res_o (out_pixel_d[b*pbf_pkg::ByteW +: pbf_pkg::ByteW])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_pixel_q <= out_pixel_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.blended_pixel = out_pixel_q;

  // A result only appears after a pixel sat in the input register.
  `PBF_ASSERT_IMP(a_no_spurious_result, $rose(out_valid_q), $past(in_valid_q))
  // A pixel in the input register moves on whenever the result side has room.
  `PBF_ASSERT_NXT(a_pixel_advances, in_valid_q && out_ready, out_valid_q)
  // With the default alpha mask and alpha preserved, the alpha byte passes intact.
  `PBF_ASSERT_NXT(a_alpha_kept,
    in_valid_q && out_ready && !u_cfg_regs.alpha_incl_q &&
    (u_cfg_regs.alpha_mask_q == pbf_pkg::AlphaMaskRst) &&
    (u_cfg_regs.blend_op_q <= pbf_pkg::OpMult),
    out_pixel_q[31:24] == $past(in_pixel_q[31:24]))

endmodule

/* bench/tb_pixel_blend_fill_unit.sv */
// Self-checking testbench for the pixel blend fill unit: randomised settings and pixel streams.
module tb_pixel_blend_fill_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomPixels = 1700;
  localparam int unsigned CycleLimit   = 200_000;
  localparam int unsigned DrainCycles  = 6;
  localparam int unsigned LongHold     = 80;

  typedef enum logic [1:0] {
    RxAlways,
    RxCoin,
    RxQuarter,
    RxMostly
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  pbf_dst_if dst_ch ();
  pbf_res_if res_ch ();
  pbf_cfg_if cfg_ch ();

  pixel_blend_fill_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dst_i  (dst_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register copies used by the predictor, starting from their reset values.
  logic [pbf_pkg::PixelW-1:0] fill_c     = pbf_pkg::FillColorRst;
  logic [pbf_pkg::OpW-1:0]    op_code    = pbf_pkg::OpAdd;
  logic [pbf_pkg::PixelW-1:0] alpha_msk  = pbf_pkg::AlphaMaskRst;
  logic                       alpha_incl = 1'b0;

  logic [pbf_pkg::PixelW-1:0] pending_pixels[$];
  logic [pbf_pkg::PixelW-1:0] expected_pixels[$];

  int unsigned err_cnt     = 0;
  int unsigned checked_cnt = 0;
  int unsigned cfg_writes  = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned hold_ask    = 0;
  logic [7:0]  ops_used    = '0;

  // Blends one destination pixel with the fill colour under the current settings.
  function automatic logic [pbf_pkg::PixelW-1:0] blend_pixel(
      input logic [pbf_pkg::PixelW-1:0] d);
    logic [pbf_pkg::PixelW-1:0] c;
    logic [pbf_pkg::PixelW-1:0] r;
    logic [pbf_pkg::ByteW-1:0]  db;
    logic [pbf_pkg::ByteW-1:0]  cb;
    logic [pbf_pkg::ByteW:0]    sum;
    logic [15:0]                prod;
    int                         k;
    c = fill_c;
    if (!alpha_incl) begin
      if (op_code == pbf_pkg::OpMin || op_code == pbf_pkg::OpMult) begin
        c = c | alpha_msk;
      end else begin
        c = c & ~alpha_msk;
      end
    end
    for (k = 0; k < pbf_pkg::NumBytes; k++) begin
      db = d[k*pbf_pkg::ByteW +: pbf_pkg::ByteW];
      cb = c[k*pbf_pkg::ByteW +: pbf_pkg::ByteW];
      case (op_code)
        pbf_pkg::OpAdd: begin
          sum = {1'b0, db} + {1'b0, cb};
          r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = sum[pbf_pkg::ByteW] ? 8'hFF
                                                                      : sum[pbf_pkg::ByteW-1:0];
        end
        pbf_pkg::OpSub:  r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = (db > cb) ? db - cb : 8'h00;
        pbf_pkg::OpMin:  r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = (db < cb) ? db : cb;
        pbf_pkg::OpMax:  r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = (db > cb) ? db : cb;
        pbf_pkg::OpMult: begin
          prod = 16'(db) * 16'(cb) + 16'd255;
          r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = prod[15:8];
        end
        default: r[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = db;
      endcase
    end
    return r;
  endfunction

  // Pixel with a bias towards byte extremes.
  function automatic logic [pbf_pkg::PixelW-1:0] rand_pixel();
    logic [pbf_pkg::PixelW-1:0] p;
    int                         k;
    p = $urandom();
    if ($urandom_range(0, 2) != 0) begin
      for (k = 0; k < pbf_pkg::NumBytes; k++) begin
        case ($urandom_range(0, 5))
          0: p[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = 8'h00;
          1: p[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = 8'hFF;
          2: p[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = 8'h01;
          3: p[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = 8'hFE;
          4: p[k*pbf_pkg::ByteW +: pbf_pkg::ByteW] = 8'h80;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic write_reg(input pbf_pkg::cfg_reg_e idx,
                           input logic [pbf_pkg::CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    case (idx)
      pbf_pkg::RegFillColor:     fill_c = value;
      pbf_pkg::RegBlendOp: begin
        op_code = value[pbf_pkg::OpW-1:0];
        ops_used[value[pbf_pkg::OpW-1:0]] = 1'b1;
      end
      pbf_pkg::RegAlphaMask:     alpha_msk = value;
      pbf_pkg::RegAlphaIncluded: alpha_incl = value[0];
      default: ;
    endcase
  endtask

  // Waits until every offered pixel has come back, then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || dst_ch.valid || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_all(input logic [pbf_pkg::PixelW-1:0] color,
                           input logic [pbf_pkg::OpW-1:0] op,
                           input logic [pbf_pkg::PixelW-1:0] mask, input logic incl);
    write_reg(pbf_pkg::RegFillColor, color);
    write_reg(pbf_pkg::RegBlendOp, pbf_pkg::CfgDataW'(op));
    write_reg(pbf_pkg::RegAlphaMask, mask);
    write_reg(pbf_pkg::RegAlphaIncluded, pbf_pkg::CfgDataW'(incl));
  endtask

  // Sender: bursts of random length separated by random gaps, some of them empty.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_ch.valid     <= 1'b0;
      dst_ch.dst_pixel <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin
      if (dst_ch.valid && dst_ch.ready) begin
        expected_pixels.push_back(blend_pixel(dst_ch.dst_pixel));
      end
      if (!dst_ch.valid || dst_ch.ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          dst_ch.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          dst_ch.valid     <= 1'b1;
          dst_ch.dst_pixel <= pending_pixels.pop_front();
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          dst_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: its own stall pattern, plus a long hold-off whenever one is requested.
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned hold_left;
  int unsigned hold_seen;
  logic [1:0]  rx_tick;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      rx_mode      <= RxAlways;
      rx_mode_left <= 0;
      hold_left    <= 0;
      hold_seen    <= 0;
      rx_tick      <= '0;
    end else begin
      rx_tick <= rx_tick + 2'd1;
      if (hold_ask != hold_seen) begin
        hold_seen    <= hold_ask;
        hold_left    <= LongHold;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= rx_mode_e'($urandom_range(0, 3));
          rx_mode_left <= $urandom_range(20, 150);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          RxAlways:  res_ch.ready <= 1'b1;
          RxCoin:    res_ch.ready <= 1'($urandom_range(0, 1));
          RxQuarter: res_ch.ready <= (rx_tick == 2'd0);
          default:   res_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Result checker: every completed transaction is compared with the oldest prediction.
  logic [pbf_pkg::PixelW-1:0] want_pixel;

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel %h", res_ch.blended_pixel));
      end else begin
        want_pixel = expected_pixels.pop_front();
        checked_cnt++;
        if (res_ch.blended_pixel !== want_pixel) begin
          report_mismatch($sformatf("pixel %0d: got %h, want %h", checked_cnt,
                                    res_ch.blended_pixel, want_pixel));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_pixels.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int unsigned                op;
    int unsigned                issued;
    int unsigned                count;
    int unsigned                phase_cnt;
    int unsigned                i;
    logic [pbf_pkg::PixelW-1:0] mask;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= pbf_pkg::RegFillColor;
    cfg_ch.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: add with a zero colour.
    pending_pixels.push_back(32'h0000_0000);
    pending_pixels.push_back(32'hFFFF_FFFF);

    // Every operation code, the three unused ones included.
    for (op = 0; op < 8; op++) begin
      wait_drained();
      write_all(32'h7F01_FF80, pbf_pkg::OpW'(op), pbf_pkg::AlphaMaskRst, 1'b0);
      pending_pixels.push_back(32'hFFFF_FFFF);
      pending_pixels.push_back(32'h8001_FE7F);
    end

    // A zero mask blends every byte.
    wait_drained();
    write_all(32'h1234_56FF, pbf_pkg::OpMin, 32'h0000_0000, 1'b0);
    pending_pixels.push_back(32'hFFFF_FFFF);
    pending_pixels.push_back(32'h00FF_8001);

    // A mask that is not byte aligned is applied bit by bit.
    wait_drained();
    write_all(32'hFFFF_FFFF, pbf_pkg::OpAdd, 32'h0F0F_00F0, 1'b0);
    pending_pixels.push_back(32'h1234_5678);
    pending_pixels.push_back(32'h0000_0000);

    // Alpha blended like any other byte.
    wait_drained();
    write_all(32'hFFFF_FFFF, pbf_pkg::OpMult, pbf_pkg::AlphaMaskRst, 1'b1);
    pending_pixels.push_back(32'hFFFF_FFFF);
    pending_pixels.push_back(32'h8080_8080);

    issued    = 0;
    phase_cnt = 0;
    while (issued < RandomPixels) begin
      wait_drained();
      phase_cnt++;
      if ($urandom_range(0, 3) != 0) begin
        write_reg(pbf_pkg::RegFillColor, rand_pixel());
      end
      if ($urandom_range(0, 3) != 0) begin
        op = $urandom_range(0, 10);
        if (op > 7) begin
          op = $urandom_range(0, 4);
        end
        write_reg(pbf_pkg::RegBlendOp, pbf_pkg::CfgDataW'(op));
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: mask = pbf_pkg::AlphaMaskRst;
          1: mask = 32'h0000_00FF;
          2: mask = 32'h0000_0000;
          3: mask = 32'hFFFF_FFFF;
          default: mask = $urandom();
        endcase
        write_reg(pbf_pkg::RegAlphaMask, mask);
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(pbf_pkg::RegAlphaIncluded, pbf_pkg::CfgDataW'($urandom_range(0, 1)));
      end
      count = $urandom_range(20, 80);
      // Now and then the receiver holds off long enough for the input to back up.
      if (phase_cnt % 12 == 3) begin
        count = 80;
        @(negedge clk_i);
        hold_ask++;
      end
      for (i = 0; i < count; i++) begin
        pending_pixels.push_back(rand_pixel());
      end
      issued += count;
    end

    wait_drained();
    $display("checked %0d pixels over %0d random settings and the directed cases,",
             checked_cnt, phase_cnt);
    $display("%0d register writes, operation codes written (bit per code): %b, hold-offs: %0d",
             cfg_writes, ops_used, hold_ask);
    if (err_cnt == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
